// File: rtl/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared constants and types of the rolling percentile rank block.
// ----------------------------------------------------------------------------
package rpr_pkg;

    // default sizes of the block
    localparam int WINDOW_MAX_DEF    = 256;
    localparam int SAMPLE_BITS_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // register map of the configuration port
    localparam int CFG_INDEX_BITS    = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SAMPLES   = 1'b1;

    // register reset values
    localparam int WINDOW_LENGTH_RESET = 20;
    localparam int MIN_SAMPLES_RESET   = -1;

    // flags that travel with a request down the cell chain
    typedef struct packed {
        logic active;
        logic missing;
    } rpr_flags_t;

endpackage

// File: rtl/rpr_cell.sv
// ----------------------------------------------------------------------------
// rpr_cell
// One window slot: holds a sample, compares it with the passing request and
// hands the updated counts to the next cell.
// ----------------------------------------------------------------------------
module rpr_cell
    import rpr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // window shift
    input  logic                          shift_en,
    input  logic signed [SAMPLE_BITS-1:0] entry_key_in,
    input  logic                          entry_missing_in,
    output logic signed [SAMPLE_BITS-1:0] entry_key_out,
    output logic                          entry_missing_out,
    // request from the previous cell
    input  rpr_flags_t                    q_flags_in,
    input  logic signed [SAMPLE_BITS-1:0] q_key_in,
    input  logic [COUNT_BITS-1:0]         q_remaining_in,
    input  logic [COUNT_BITS-1:0]         q_lower_in,
    input  logic [COUNT_BITS-1:0]         q_equal_in,
    // request to the next cell
    output rpr_flags_t                    q_flags_out,
    output logic signed [SAMPLE_BITS-1:0] q_key_out,
    output logic [COUNT_BITS-1:0]         q_remaining_out,
    output logic [COUNT_BITS-1:0]         q_lower_out,
    output logic [COUNT_BITS-1:0]         q_equal_out
);

    logic signed [SAMPLE_BITS-1:0] entry_key_reg;
    logic                          entry_missing_reg;
    rpr_flags_t                    q_flags_reg;
    logic signed [SAMPLE_BITS-1:0] q_key_reg;
    logic [COUNT_BITS-1:0]         q_remaining_reg, q_remaining_next;
    logic [COUNT_BITS-1:0]         q_lower_reg, q_lower_next;
    logic [COUNT_BITS-1:0]         q_equal_reg, q_equal_next;
    logic                          in_window;
    logic                          compare_en;

    // stored sample, moves one slot older on every accepted sample
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_key_reg     <= entry_key_in;
            entry_missing_reg <= entry_missing_in;
        end
    end

    // compare against the stored sample while the slot is inside the window
    always_comb begin
        in_window        = (q_remaining_in != '0);
        compare_en       = in_window && !q_flags_in.missing && !entry_missing_reg;
        q_remaining_next = in_window ? q_remaining_in - 1'b1 : q_remaining_in;
        q_lower_next     = q_lower_in;
        q_equal_next     = q_equal_in;
        if (compare_en) begin
            if (entry_key_reg < q_key_in) begin
                q_lower_next = q_lower_in + 1'b1;
            end else if (entry_key_reg == q_key_in) begin
                q_equal_next = q_equal_in + 1'b1;
            end
        end
    end

    // request stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_flags_reg <= '0;
        end else begin
            q_flags_reg <= q_flags_in;
        end
    end

    // request stage payload
    always_ff @(posedge aclk) begin
        q_key_reg       <= q_key_in;
        q_remaining_reg <= q_remaining_next;
        q_lower_reg     <= q_lower_next;
        q_equal_reg     <= q_equal_next;
    end

    assign entry_key_out     = entry_key_reg;
    assign entry_missing_out = entry_missing_reg;
    assign q_flags_out       = q_flags_reg;
    assign q_key_out         = q_key_reg;
    assign q_remaining_out   = q_remaining_reg;
    assign q_lower_out       = q_lower_reg;
    assign q_equal_out       = q_equal_reg;

endmodule

// File: rtl/rpr_divider.sv
// ----------------------------------------------------------------------------
// rpr_divider
// Restoring divider for the rank fraction, one quotient bit per cycle.
// Expects numer <= denom, so the quotient is at most 1.0.
// ----------------------------------------------------------------------------
module rpr_divider #(
    parameter int COUNT_BITS    = 9,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [COUNT_BITS:0]      numer,
    input  logic [COUNT_BITS:0]      denom,
    input  logic                     take,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quotient
);

    localparam int STEP_BITS = $clog2(FRACTION_BITS + 1);

    logic                     run_reg;
    logic                     done_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [COUNT_BITS+1:0]    rem_reg, rem_next;
    logic [COUNT_BITS:0]      denom_reg;
    logic [FRACTION_BITS:0]   quot_reg, quot_next;
    logic [COUNT_BITS+1:0]    diff;
    logic                     fits;

    // one trial subtraction per step
    always_comb begin
        diff = rem_reg - {1'b0, denom_reg};
        fits = (rem_reg >= {1'b0, denom_reg});
        if (fits) begin
            rem_next  = {diff[COUNT_BITS:0], 1'b0};
            quot_next = {quot_reg[FRACTION_BITS-1:0], 1'b1};
        end else begin
            rem_next  = {rem_reg[COUNT_BITS:0], 1'b0};
            quot_next = {quot_reg[FRACTION_BITS-1:0], 1'b0};
        end
    end

    // step sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (run_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_BITS'(FRACTION_BITS)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end else if (take) begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= {1'b0, numer};
            denom_reg <= denom;
        end else if (run_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/rolling_percentile_rank.sv
// ----------------------------------------------------------------------------
// rolling_percentile_rank
// Percentile rank of each sample within a sliding window of recent samples.
// ----------------------------------------------------------------------------
// Input stream s_axis: one sample per request, tuser carries the missing and
// start-of-series flags. Output stream m_axis: one result per sample with the
// rank as Q1.FRACTION_BITS, the lower and equal counts and the window fill;
// tuser carries the rank valid flag.
// Configuration: cfg_wr_en/cfg_wr_index/cfg_wr_data, index 0 window_length,
// index 1 min_samples; write only while no sample is in flight.
// Each sample is shifted into a chain of WINDOW_MAX cells; the compare
// request then walks the chain one cell per cycle and a serial divider makes
// one quotient bit per cycle. One sample is processed at a time and the next is
// taken the cycle after the result is loaded, so the interval between samples
// is set by the chain walk and the divider.
// A finished result waits in the output register while the next sample is
// taken; if the receiver stalls, the following result holds in the divider
// and s_axis_tready stays low until it moves out.
// Reset clears the sample count and the configuration to window_length 20 and
// min_samples -1; window contents need no clearing.
// ----------------------------------------------------------------------------
module rolling_percentile_rank
    import rpr_pkg::*;
#(
    parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int COUNT_BITS    = $clog2(WINDOW_MAX + 1),
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = ((FRACTION_BITS + 1 + 3 * COUNT_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,   // sample
    input  logic [1:0]                s_axis_tuser,   // missing, start_of_series
    // output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,   // rank_fraction, lower_count,
                                                      // equal_count, window_fill
    output logic [0:0]                m_axis_tuser,   // rank_valid
    // configuration writes
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [COUNT_BITS:0]       cfg_wr_data
);

    localparam int THIRD_SHIFT = COUNT_BITS + 2;
    localparam int THIRD_MULT  = (2 ** THIRD_SHIFT + 2) / 3;
    localparam int PROD_BITS   = COUNT_BITS + THIRD_SHIFT;

    // configuration and derived limits
    logic [COUNT_BITS-1:0]         window_length_reg;
    logic signed [COUNT_BITS:0]    min_samples_reg;
    logic [COUNT_BITS-1:0]         eff_window;
    logic [PROD_BITS-1:0]          third_prod;
    logic [COUNT_BITS-1:0]         window_third;
    logic [COUNT_BITS-1:0]         eff_min_reg, eff_min_next;

    // sample count and window fill
    logic                          s_accept;
    logic [COUNT_BITS-1:0]         samples_seen_reg, samples_seen_next;
    logic [COUNT_BITS-1:0]         seen_base;
    logic [COUNT_BITS-1:0]         fill_reg, fill_next;
    logic                          busy_reg;

    // request injection
    rpr_flags_t                    inj_flags_reg;
    logic signed [SAMPLE_BITS-1:0] inj_key_reg;

    // chain links
    logic signed [SAMPLE_BITS-1:0] entry_key_w     [0:WINDOW_MAX];
    logic                          entry_missing_w [0:WINDOW_MAX];
    rpr_flags_t                    q_flags_w       [0:WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] q_key_w         [0:WINDOW_MAX];
    logic [COUNT_BITS-1:0]         q_remaining_w   [0:WINDOW_MAX];
    logic [COUNT_BITS-1:0]         q_lower_w       [0:WINDOW_MAX];
    logic [COUNT_BITS-1:0]         q_equal_w       [0:WINDOW_MAX];

    // counts captured at the chain end
    logic                          tail_done;
    logic [COUNT_BITS-1:0]         lower_reg;
    logic [COUNT_BITS-1:0]         equal_reg;
    logic                          rank_valid_reg;
    logic [COUNT_BITS:0]           div_numer;
    logic [COUNT_BITS:0]           div_denom;
    logic                          div_done;
    logic [FRACTION_BITS:0]        div_quotient;
    logic                          out_load;

    // output register
    logic                          m_valid_reg;
    logic [FRACTION_BITS:0]        m_rank_reg;
    logic                          m_rank_valid_reg;
    logic [COUNT_BITS-1:0]         m_lower_reg;
    logic [COUNT_BITS-1:0]         m_equal_reg;
    logic [COUNT_BITS-1:0]         m_fill_reg;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= COUNT_BITS'(WINDOW_LENGTH_RESET);
            min_samples_reg   <= (COUNT_BITS + 1)'(MIN_SAMPLES_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_WINDOW_LENGTH: window_length_reg <= cfg_wr_data[COUNT_BITS-1:0];
                REG_MIN_SAMPLES:   min_samples_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // window length clamped to one through WINDOW_MAX
    always_comb begin
        if (window_length_reg == '0) begin
            eff_window = COUNT_BITS'(1);
        end else if (window_length_reg > COUNT_BITS'(WINDOW_MAX)) begin
            eff_window = COUNT_BITS'(WINDOW_MAX);
        end else begin
            eff_window = window_length_reg;
        end
    end

    // default minimum is a third of the window, by reciprocal multiply
    assign third_prod   = PROD_BITS'(eff_window) * PROD_BITS'(THIRD_MULT);
    assign window_third = third_prod[PROD_BITS-1:THIRD_SHIFT];

    // effective minimum, never below one
    always_comb begin
        if (min_samples_reg == '1) begin
            eff_min_next = window_third;
        end else if (min_samples_reg < 1) begin
            eff_min_next = '0;
        end else begin
            eff_min_next = min_samples_reg[COUNT_BITS-1:0];
        end
        if (eff_min_next == '0) begin
            eff_min_next = COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_min_reg <= COUNT_BITS'(1);
        end else begin
            eff_min_reg <= eff_min_next;
        end
    end

    // sample count, restarted by start of series, saturating at WINDOW_MAX
    assign s_axis_tready = !busy_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        seen_base         = s_axis_tuser[1] ? '0 : samples_seen_reg;
        samples_seen_next = (seen_base < COUNT_BITS'(WINDOW_MAX)) ?
                            seen_base + 1'b1 : seen_base;
        fill_next         = (samples_seen_next < eff_window) ?
                            samples_seen_next : eff_window;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_seen_reg <= '0;
            busy_reg         <= 1'b0;
            inj_flags_reg    <= '0;
        end else begin
            inj_flags_reg.active  <= s_accept;
            inj_flags_reg.missing <= s_axis_tuser[0];
            if (s_accept) begin
                samples_seen_reg <= samples_seen_next;
                busy_reg         <= 1'b1;
            end else if (out_load) begin
                busy_reg         <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fill_reg    <= fill_next;
            inj_key_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // head of the chain: new sample and its compare request
    assign entry_key_w[0]     = s_axis_tdata[SAMPLE_BITS-1:0];
    assign entry_missing_w[0] = s_axis_tuser[0];
    assign q_flags_w[0]       = inj_flags_reg;
    assign q_key_w[0]         = inj_key_reg;
    assign q_remaining_w[0]   = fill_reg;
    assign q_lower_w[0]       = '0;
    assign q_equal_w[0]       = '0;

    // chain of window cells, newest sample first
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        rpr_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COUNT_BITS  (COUNT_BITS)
        ) u_cell (
            .aclk              (aclk),
            .aresetn           (aresetn),
            .shift_en          (s_accept),
            .entry_key_in      (entry_key_w[k]),
            .entry_missing_in  (entry_missing_w[k]),
            .entry_key_out     (entry_key_w[k+1]),
            .entry_missing_out (entry_missing_w[k+1]),
            .q_flags_in        (q_flags_w[k]),
            .q_key_in          (q_key_w[k]),
            .q_remaining_in    (q_remaining_w[k]),
            .q_lower_in        (q_lower_w[k]),
            .q_equal_in        (q_equal_w[k]),
            .q_flags_out       (q_flags_w[k+1]),
            .q_key_out         (q_key_w[k+1]),
            .q_remaining_out   (q_remaining_w[k+1]),
            .q_lower_out       (q_lower_w[k+1]),
            .q_equal_out       (q_equal_w[k+1])
        );
    end

    // capture counts when the request leaves the chain
    assign tail_done = q_flags_w[WINDOW_MAX].active;

    always_ff @(posedge aclk) begin
        if (tail_done) begin
            lower_reg      <= q_lower_w[WINDOW_MAX];
            equal_reg      <= q_equal_w[WINDOW_MAX];
            rank_valid_reg <= (samples_seen_reg >= eff_min_reg);
        end
    end

    // rank = (2*lower + equal) / (2*fill)
    assign div_numer = {q_lower_w[WINDOW_MAX], 1'b0} + (COUNT_BITS + 1)'(q_equal_w[WINDOW_MAX]);
    assign div_denom = {fill_reg, 1'b0};
    assign out_load  = div_done && (!m_valid_reg || m_axis_tready);

    rpr_divider #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tail_done),
        .numer    (div_numer),
        .denom    (div_denom),
        .take     (out_load),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_rank_reg       <= rank_valid_reg ? div_quotient : '0;
            m_rank_valid_reg <= rank_valid_reg;
            m_lower_reg      <= lower_reg;
            m_equal_reg      <= equal_reg;
            m_fill_reg       <= fill_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({m_fill_reg, m_equal_reg, m_lower_reg, m_rank_reg});
    assign m_axis_tuser  = m_rank_valid_reg;

endmodule
